[src/diwc_pkg.sv]
package diwc_pkg;

    // Block sizing
    localparam int NUM_CHANNELS  = 16;
    localparam int SAMPLE_BITS   = 10;
    localparam int CHAN_BITS     = 4;
    localparam int WORD_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_24V = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_5V  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HI_24V   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LO_24V   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFF_24V  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HI_5V    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_LO_5V    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFF_5V   = 3'd7;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CHAN_BITS-1:0]   t_chan;
    typedef logic [WORD_BITS-1:0]   t_word;

    // One voltage window
    typedef struct packed {
        t_sample hi;
        t_sample lo;
        t_sample off;
    } t_window;

    // Full configuration as seen by the datapath
    typedef struct packed {
        t_word   mask_24v;
        t_word   mask_5v;
        t_window win_24v;
        t_window win_5v;
    } t_cfg;

    // Classification of one sample
    typedef struct packed {
        logic level;
        logic fault;
        logic in_range;
    } t_class;

endpackage

[src/diwc_ifs.sv]
interface diwc_in_if;
    logic                   valid;
    logic                   ready;
    diwc_pkg::t_chan        channel;
    diwc_pkg::t_sample      sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface diwc_out_if;
    logic                   valid;
    logic                   ready;
    diwc_pkg::t_chan        chan_out;
    logic                   level;
    logic                   fault;
    diwc_pkg::t_word        levels_word;
    diwc_pkg::t_word        faults_word;

    modport source (output valid, output chan_out, output level, output fault,
                    output levels_word, output faults_word, input ready);
    modport sink   (input valid, input chan_out, input level, input fault,
                    input levels_word, input faults_word, output ready);
endinterface

interface diwc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [diwc_pkg::CFG_IDX_BITS-1:0]      index;
    logic [diwc_pkg::CFG_DATA_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/diwc_cfg_regs.sv]
module diwc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    diwc_cfg_if.sink       i_cfg,
    output diwc_pkg::t_cfg o_cfg
);
    import diwc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always ready; a write lands in the addressed register
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MASK_24V: n_cfg.mask_24v    = i_cfg.data[WORD_BITS-1:0];
                REG_MASK_5V:  n_cfg.mask_5v     = i_cfg.data[WORD_BITS-1:0];
                REG_HI_24V:   n_cfg.win_24v.hi  = i_cfg.data[SAMPLE_BITS-1:0];
                REG_LO_24V:   n_cfg.win_24v.lo  = i_cfg.data[SAMPLE_BITS-1:0];
                REG_OFF_24V:  n_cfg.win_24v.off = i_cfg.data[SAMPLE_BITS-1:0];
                REG_HI_5V:    n_cfg.win_5v.hi   = i_cfg.data[SAMPLE_BITS-1:0];
                REG_LO_5V:    n_cfg.win_5v.lo   = i_cfg.data[SAMPLE_BITS-1:0];
                REG_OFF_5V:   n_cfg.win_5v.off  = i_cfg.data[SAMPLE_BITS-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/diwc_classify.sv]
module diwc_classify (
    input  diwc_pkg::t_cfg    i_cfg,
    input  diwc_pkg::t_chan   i_channel,
    input  diwc_pkg::t_sample i_sample,
    output diwc_pkg::t_class  o_class
);
    import diwc_pkg::*;

    logic    in_range;
    logic    use_24v;
    logic    use_5v;
    t_window win;
    logic    in_window;
    logic    below_off;

    // Pick the window: 24 V mask wins over 5 V mask
    assign in_range  = 32'(i_channel) < NUM_CHANNELS;
    assign use_24v   = i_cfg.mask_24v[i_channel];
    assign use_5v    = i_cfg.mask_5v[i_channel];
    assign win       = use_24v ? i_cfg.win_24v : i_cfg.win_5v;

    // Window and off-threshold compares
    assign in_window = (i_sample <= win.hi) && (i_sample >= win.lo);
    assign below_off = i_sample < win.off;

    always_comb begin
        o_class.in_range = in_range;
        if (in_range && (use_24v || use_5v)) begin
            if (in_window) begin
                o_class.level = 1'b1;
                o_class.fault = 1'b0;
            end else if (below_off) begin
                o_class.level = 1'b0;
                o_class.fault = 1'b0;
            end else begin
                o_class.level = 1'b1;
                o_class.fault = 1'b1;
            end
        end else begin
            // unassigned or out-of-range channel
            o_class.level = 1'b0;
            o_class.fault = 1'b1;
        end
    end

endmodule

[src/discrete_input_window_classifier.sv]
// Channel   Dir   Handshake      Word
// i_cfg     in    valid/ready    index (3 b), data (16 b); ready always high
// i_in      in    valid/ready    channel (4 b), sample (10 b)
// o_out     out   valid/ready    chan_out, level, fault, levels_word, faults_word
//
// The input register loads at the accepting edge; classification and word update
// then load the result register, which raises the result valid.
// One word per cycle sustained while o_out is ready; both stages advance whenever the result
// register is empty or being taken, so a stall on o_out backs up into i_in.
// Synchronous active-low reset clears the valid flags, config registers, level and fault words.
module discrete_input_window_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    diwc_cfg_if.sink    i_cfg,
    diwc_in_if.sink     i_in,
    diwc_out_if.source  o_out
);
    import diwc_pkg::*;

    t_cfg    cfg;
    t_class  cls;

    logic    r_s1_valid;
    t_chan   r_s1_channel;
    t_sample r_s1_sample;

    logic    r_out_valid;
    t_chan   r_chan_out;
    logic    r_level;
    logic    r_fault;
    t_word   r_levels_word;
    t_word   r_faults_word;

    t_word   r_level_bits;
    t_word   r_fault_bits;
    t_word   n_level_bits;
    t_word   n_fault_bits;

    logic    s1_advance;
    logic    in_fire;

    diwc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    diwc_classify u_classify (
        .i_cfg     (cfg),
        .i_channel (r_s1_channel),
        .i_sample  (r_s1_sample),
        .o_class   (cls)
    );

    // Advance stage 1 when the result register is free or being drained
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_fire    = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_channel <= i_in.channel;
            r_s1_sample  <= i_in.sample;
        end
    end

    // Update the channel's bits in the level and fault words
    always_comb begin
        n_level_bits = r_level_bits;
        n_fault_bits = r_fault_bits;
        if (cls.in_range) begin
            n_level_bits[r_s1_channel] = cls.level;
            n_fault_bits[r_s1_channel] = cls.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_bits <= '0;
            r_fault_bits <= '0;
        end else if (s1_advance) begin
            r_level_bits <= n_level_bits;
            r_fault_bits <= n_fault_bits;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_chan_out    <= r_s1_channel;
            r_level       <= cls.level;
            r_fault       <= cls.fault;
            r_levels_word <= n_level_bits;
            r_faults_word <= n_fault_bits;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.chan_out    = r_chan_out;
    assign o_out.level       = r_level;
    assign o_out.fault       = r_fault;
    assign o_out.levels_word = r_levels_word;
    assign o_out.faults_word = r_faults_word;

endmodule

[tb/sv/diwc_tb_pkg.sv]
`timescale 1ns / 1ps
package diwc_tb_pkg;
    import diwc_pkg::*;

    // One classified word as it leaves the block
    typedef struct packed {
        t_chan chan;
        logic  level;
        logic  fault;
        t_word levels;
        t_word faults;
    } t_reading;

    class reading_scoreboard;
        t_word       mask_24v;
        t_word       mask_5v;
        t_sample     hi_24v, lo_24v, off_24v;
        t_sample     hi_5v, lo_5v, off_5v;
        t_word       level_bits;
        t_word       fault_bits;
        t_reading    expected_readings[$];
        int unsigned mismatches;

        function new();
            mask_24v   = '0;
            mask_5v    = '0;
            hi_24v     = '0;
            lo_24v     = '0;
            off_24v    = '0;
            hi_5v      = '0;
            lo_5v      = '0;
            off_5v     = '0;
            level_bits = '0;
            fault_bits = '0;
            mismatches = 0;
        endfunction

        // Mirror a register write, cut to the register width
        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_MASK_24V: mask_24v = data;
                REG_MASK_5V:  mask_5v  = data;
                REG_HI_24V:   hi_24v   = data[SAMPLE_BITS-1:0];
                REG_LO_24V:   lo_24v   = data[SAMPLE_BITS-1:0];
                REG_OFF_24V:  off_24v  = data[SAMPLE_BITS-1:0];
                REG_HI_5V:    hi_5v    = data[SAMPLE_BITS-1:0];
                REG_LO_5V:    lo_5v    = data[SAMPLE_BITS-1:0];
                REG_OFF_5V:   off_5v   = data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Sort a sample against one window: on, cleanly off, or forbidden zone
        function void judge_window(t_sample s, t_sample hi, t_sample lo, t_sample off,
                                   output logic level, output logic fault);
            if (s <= hi && s >= lo) begin
                level = 1'b1;
                fault = 1'b0;
            end else if (s < off) begin
                level = 1'b0;
                fault = 1'b0;
            end else begin
                level = 1'b1;
                fault = 1'b1;
            end
        endfunction

        // Classify an accepted sample, update the words, queue the result
        function void note_sample(t_chan ch, t_sample s);
            t_reading r;
            r.chan  = ch;
            r.level = 1'b0;
            r.fault = 1'b1;
            if (int'(ch) < NUM_CHANNELS) begin
                // 24 V mask wins when both are set
                if (mask_24v[ch])
                    judge_window(s, hi_24v, lo_24v, off_24v, r.level, r.fault);
                else if (mask_5v[ch])
                    judge_window(s, hi_5v, lo_5v, off_5v, r.level, r.fault);
                level_bits[ch] = r.level;
                fault_bits[ch] = r.fault;
            end
            r.levels = level_bits;
            r.faults = fault_bits;
            expected_readings.push_back(r);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
        endfunction

        // Compare a result word with the oldest prediction
        function void check_reading(t_reading got);
            t_reading want;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: unexpected word: expected none, actual %h",
                             $time, got);
                return;
            end
            want = expected_readings.pop_front();
            if (got.chan !== want.chan)     report("chan_out", want.chan, got.chan);
            if (got.level !== want.level)   report("level", want.level, got.level);
            if (got.fault !== want.fault)   report("fault", want.fault, got.fault);
            if (got.levels !== want.levels) report("levels_word", want.levels, got.levels);
            if (got.faults !== want.faults) report("faults_word", want.faults, got.faults);
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction
    endclass

endpackage

[tb/sv/discrete_input_window_classifier_tb.sv]
`timescale 1ns / 1ps
module discrete_input_window_classifier_tb;
    import diwc_pkg::*;
    import diwc_tb_pkg::*;

    typedef t_word t_regfile [8];
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} t_rx_pattern;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 110;
    localparam int LONG_HOLD     = 60;
    localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;

    logic i_clk;
    logic i_rst_n;

    diwc_in_if  in_if ();
    diwc_out_if out_if ();
    diwc_cfg_if cfg_if ();

    discrete_input_window_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    reading_scoreboard sb = new();
    t_rx_pattern rx_pattern   = RX_ALWAYS;
    int          gap_max      = 0;
    int          burst_left   = 0;
    logic        hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Track register writes, check results, then note accepted samples
    always @(posedge i_clk) begin
        t_reading seen;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_register(cfg_if.index, cfg_if.data);
            if (out_if.valid && out_if.ready) begin
                seen.chan   = out_if.chan_out;
                seen.level  = out_if.level;
                seen.fault  = out_if.fault;
                seen.levels = out_if.levels_word;
                seen.faults = out_if.faults_word;
                sb.check_reading(seen);
            end
            if (in_if.valid && in_if.ready)
                sb.note_sample(in_if.channel, in_if.sample);
        end
    end

    // Drive result ready on its own pattern; hold off for a long stretch on request
    initial begin : receiver
        int unsigned tick;
        tick = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            case (rx_pattern)
                RX_ALWAYS:   out_if.ready <= 1'b1;
                RX_MOSTLY:   out_if.ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: out_if.ready <= ((tick % 8) >= 3);
                default:     out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one sample word; open a new burst after a random gap when one runs out
    task automatic push_sample(input t_chan ch, input t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 12));
        end
        in_if.valid   <= 1'b1;
        in_if.channel <= ch;
        in_if.sample  <= s;
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
    endtask

    task automatic stop_stream();
        in_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Let the monitor note the last word, wait until every predicted word
    // has come out, then let the pipe settle
    task automatic drain();
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_word data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Write all registers back to back while the block is idle
    task automatic apply_settings(input t_regfile regs);
        drain();
        for (int i = 0; i < 8; i++)
            put_reg(i[CFG_IDX_BITS-1:0], regs[i]);
        cfg_if.valid <= 1'b0;
    endtask

    // Now and then set bits above the register width; they must be dropped
    function automatic t_word widen(t_word v);
        if ($urandom_range(0, 9) == 0)
            v[WORD_BITS-1:SAMPLE_BITS] = (WORD_BITS-SAMPLE_BITS)'($urandom);
        return v;
    endfunction

    function automatic void random_window(output t_word hi, output t_word lo,
                                          output t_word off);
        case ($urandom_range(0, 5))
            // anything, empty windows included
            0: begin
                hi  = t_word'($urandom_range(0, FULL_SCALE));
                lo  = t_word'($urandom_range(0, FULL_SCALE));
                off = t_word'($urandom_range(0, FULL_SCALE));
            end
            // rail values only
            1: begin
                hi  = $urandom_range(0, 1) ? t_word'(FULL_SCALE) : '0;
                lo  = $urandom_range(0, 1) ? t_word'(FULL_SCALE) : '0;
                off = $urandom_range(0, 1) ? t_word'(FULL_SCALE) : '0;
            end
            // well-formed: off <= lo <= hi
            default: begin
                lo  = t_word'($urandom_range(0, FULL_SCALE));
                hi  = t_word'($urandom_range(lo, FULL_SCALE));
                off = t_word'($urandom_range(0, lo));
            end
        endcase
        hi  = widen(hi);
        lo  = widen(lo);
        off = widen(off);
    endfunction

    function automatic t_regfile random_settings();
        t_regfile r;
        r[REG_MASK_24V] = t_word'($urandom_range(0, 16'hFFFF));
        r[REG_MASK_5V]  = t_word'($urandom_range(0, 16'hFFFF));
        random_window(r[REG_HI_24V], r[REG_LO_24V], r[REG_OFF_24V]);
        random_window(r[REG_HI_5V], r[REG_LO_5V], r[REG_OFF_5V]);
        return r;
    endfunction

    // Bias samples toward the thresholds and the rails
    function automatic t_sample pick_sample(t_regfile r);
        t_word mark;
        int    v;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return t_sample'(FULL_SCALE);
            2, 3, 4: begin
                case ($urandom_range(0, 5))
                    0:       mark = r[REG_HI_24V];
                    1:       mark = r[REG_LO_24V];
                    2:       mark = r[REG_OFF_24V];
                    3:       mark = r[REG_HI_5V];
                    4:       mark = r[REG_LO_5V];
                    default: mark = r[REG_OFF_5V];
                endcase
                v = int'(mark[SAMPLE_BITS-1:0]) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                if (v > FULL_SCALE) v = FULL_SCALE;
                return t_sample'(v);
            end
            default: return t_sample'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    initial begin : stimulus
        t_regfile regs;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.channel  <= '0;
        in_if.sample   <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Masks clear after reset: every channel is unassigned
        push_sample(4'd0, 10'd0);
        push_sample(4'd15, 10'h3FF);
        stop_stream();

        // Both windows well formed; channels 4..7 sit in both masks
        regs[REG_MASK_24V] = 16'h00FF;
        regs[REG_MASK_5V]  = 16'h0FF0;
        regs[REG_HI_24V]   = 16'd800;
        regs[REG_LO_24V]   = 16'd600;
        regs[REG_OFF_24V]  = 16'd200;
        regs[REG_HI_5V]    = 16'd900;
        regs[REG_LO_5V]    = 16'd700;
        regs[REG_OFF_5V]   = 16'd300;
        apply_settings(regs);
        push_sample(4'd0, 10'd600);
        push_sample(4'd0, 10'd800);
        push_sample(4'd0, 10'd599);
        push_sample(4'd0, 10'd801);
        push_sample(4'd0, 10'd199);
        push_sample(4'd0, 10'd200);
        push_sample(4'd0, 10'd0);
        push_sample(4'd0, 10'd1023);
        push_sample(4'd5, 10'd650);
        push_sample(4'd6, 10'd850);
        push_sample(4'd9, 10'd700);
        push_sample(4'd9, 10'd900);
        push_sample(4'd9, 10'd299);
        push_sample(4'd9, 10'd300);
        push_sample(4'd9, 10'd950);
        push_sample(4'd12, 10'd500);
        stop_stream();

        // Empty 5 V window, wide register data cut to ten bits
        regs[REG_MASK_24V] = 16'h0000;
        regs[REG_MASK_5V]  = 16'hFFFF;
        regs[REG_HI_24V]   = 16'hFFFF;
        regs[REG_LO_24V]   = 16'hFFFF;
        regs[REG_OFF_24V]  = 16'hFFFF;
        regs[REG_HI_5V]    = 16'hFC64;
        regs[REG_LO_5V]    = 16'd900;
        regs[REG_OFF_5V]   = 16'd500;
        apply_settings(regs);
        push_sample(4'd3, 10'd499);
        push_sample(4'd3, 10'd500);
        push_sample(4'd10, 10'd950);
        stop_stream();

        // Full-scale 24 V window on every channel
        regs[REG_MASK_24V] = 16'hFFFF;
        regs[REG_LO_24V]   = 16'd0;
        regs[REG_OFF_24V]  = 16'd0;
        apply_settings(regs);
        push_sample(4'd1, 10'd0);
        push_sample(4'd14, 10'h3FF);
        stop_stream();

        // Random settings per phase, varied idling, one long receiver hold-off
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            regs = random_settings();
            apply_settings(regs);
            gap_max    = (p % 3 == 0) ? 0 : int'($urandom_range(1, 6));
            rx_pattern = t_rx_pattern'(p % 4);
            if (p == 2) begin
                gap_max      = 0;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_sample(t_chan'($urandom_range(0, NUM_CHANNELS - 1)),
                            pick_sample(regs));
            stop_stream();
        end

        drain();
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
src/diwc_pkg.sv
src/diwc_ifs.sv
src/diwc_cfg_regs.sv
src/diwc_classify.sv
src/discrete_input_window_classifier.sv
tb/sv/diwc_tb_pkg.sv
tb/sv/discrete_input_window_classifier_tb.sv
